### sv/ilha_pkg.sv
package ilha_pkg;

  localparam int TAG_W = 32;
  localparam int OFF_W = 64;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NOP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [TAG_W-1:0] TAG_PROLOGUE = 32'h9;
  localparam logic [TAG_W-1:0] TAG_EPILOGUE = 32'h1;

  // size field of a tag as an offset-wide value
  function automatic logic [OFF_W-1:0] tag_size(input logic [TAG_W-1:0] t);
    tag_size = {{(OFF_W-TAG_W){1'b0}}, t[TAG_W-1:3], 3'b000};
  endfunction

endpackage

### sv/implicit_list_heap_allocator.sv
// Allocate: first-fit search over the blocks, one header read per cycle; the heap grows
// when no block fits. The next request is taken in the cycle after the result beat.
// Every tag access goes through the one read port and the one write port of the tag memory.
// Reset: synchronous, active low; afterwards a clearing pass writes every tag word once
// and lays out prologue, first chunk and epilogue.
module implicit_list_heap_allocator #(
  parameter int HEAP_WORDS  = 16384,
  parameter int CHUNK_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [15:0] in_req_size,
  input  logic [15:0] in_block_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_result_addr,
  output logic [1:0]  out_status
);
  import ilha_pkg::*;

  localparam int AW = $clog2(HEAP_WORDS);
  localparam int BW = $clog2(HEAP_WORDS * 4 + 1);
  localparam logic [OFF_W-1:0] LIMIT = 64'(HEAP_WORDS) << 2;
  localparam int CHUNK_W = CHUNK_BYTES / 4;
  localparam logic [OFF_W-1:0] CHUNK_S = 64'((CHUNK_W + (CHUNK_W % 2)) * 4);
  localparam logic [OFF_W-1:0] CHUNK_L = 64'(CHUNK_BYTES);
  localparam int NS = 44;

  typedef enum logic [NS-1:0] {
    S_CLR   = NS'(1) << 0,  S_INIT1 = NS'(1) << 1,  S_INIT2 = NS'(1) << 2,
    S_INIT3 = NS'(1) << 3,  S_IDLE  = NS'(1) << 4,  S_OUT   = NS'(1) << 5,
    S_FF0   = NS'(1) << 6,  S_FF1   = NS'(1) << 7,  S_G0    = NS'(1) << 8,
    S_G1    = NS'(1) << 9,  S_G2    = NS'(1) << 10, S_G3    = NS'(1) << 11,
    S_G4    = NS'(1) << 12, S_M0    = NS'(1) << 13, S_M1    = NS'(1) << 14,
    S_M2    = NS'(1) << 15, S_M3    = NS'(1) << 16, S_M4    = NS'(1) << 17,
    S_M5    = NS'(1) << 18, S_MP1   = NS'(1) << 19, S_MP2   = NS'(1) << 20,
    S_MN1   = NS'(1) << 21, S_MN2   = NS'(1) << 22, S_MN3   = NS'(1) << 23,
    S_MN4   = NS'(1) << 24, S_MB1   = NS'(1) << 25, S_MB2   = NS'(1) << 26,
    S_MB3   = NS'(1) << 27, S_MB4   = NS'(1) << 28, S_MB5   = NS'(1) << 29,
    S_MB6   = NS'(1) << 30, S_C0    = NS'(1) << 31, S_C1    = NS'(1) << 32,
    S_CS1   = NS'(1) << 33, S_CS2   = NS'(1) << 34, S_CS3   = NS'(1) << 35,
    S_CS4   = NS'(1) << 36, S_CS5   = NS'(1) << 37, S_CN1   = NS'(1) << 38,
    S_CN2   = NS'(1) << 39, S_F0    = NS'(1) << 40, S_F1    = NS'(1) << 41,
    S_F2    = NS'(1) << 42, S_F3    = NS'(1) << 43
  } state_t;

  typedef enum logic [1:0] {
    MD_INIT  = 2'd0,
    MD_ALLOC = 2'd1,
    MD_FREE  = 2'd2
  } mode_t;

  state_t           state_r, state_nxt;
  mode_t            mode_r, mode_nxt;
  logic [OFF_W-1:0] bp_r, bp_nxt;
  logic [OFF_W-1:0] pv_r, pv_nxt;
  logic [OFF_W-1:0] a_r, a_nxt;
  logic [OFF_W-1:0] s_r, s_nxt;
  logic [OFF_W-1:0] psz_r, psz_nxt;
  logic [TAG_W-1:0] cs_r, cs_nxt;
  logic [16:0]      need_r, need_nxt;
  logic             pu_r, pu_nxt;
  logic [BW-1:0]    brk_r, brk_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [15:0]      res_r, res_nxt;
  logic [1:0]       st_r, st_nxt;

  logic [OFF_W-1:0] rd_off, wr_off, wr_val;
  logic             wr_en, rd_in_r;
  logic [TAG_W-1:0] ram_q, rv;
  logic [OFF_W-1:0] sz, need64, grow_s, diff;
  state_t           merge_ret;

  assign rv     = rd_in_r ? ram_q : '0;
  assign sz     = tag_size(rv);
  assign need64 = {{(OFF_W-17){1'b0}}, need_r};
  assign diff   = sz - need64;
  assign grow_s = (mode_r == MD_INIT) ? CHUNK_S : ((need64 > CHUNK_L) ? need64 : CHUNK_S);

  always_comb begin
    unique case (mode_r)
      MD_ALLOC: merge_ret = S_C0;
      MD_FREE:  merge_ret = S_OUT;
      default:  merge_ret = S_IDLE;
    endcase
  end

  ilha_tag_ram #(.DEPTH(HEAP_WORDS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (wr_en && (wr_off < LIMIT)),
    .waddr (wr_off[AW+1:2]),
    .wdata (wr_val[TAG_W-1:0]),
    .raddr (rd_off[AW+1:2]),
    .rdata (ram_q)
  );

  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    bp_nxt    = bp_r;
    pv_nxt    = pv_r;
    a_nxt     = a_r;
    s_nxt     = s_r;
    psz_nxt   = psz_r;
    cs_nxt    = cs_r;
    need_nxt  = need_r;
    pu_nxt    = pu_r;
    brk_nxt   = brk_r;
    clr_nxt   = clr_r;
    res_nxt   = res_r;
    st_nxt    = st_r;
    rd_off    = '0;
    wr_en     = 1'b0;
    wr_off    = '0;
    wr_val    = '0;
    unique case (state_r)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_off  = {{(OFF_W-AW-2){1'b0}}, clr_r, 2'b00};
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(HEAP_WORDS - 1)) begin
          state_nxt = S_INIT1;
        end
      end
      S_INIT1: begin
        wr_en = 1'b1; wr_off = 64'd4; wr_val = 64'(TAG_PROLOGUE);
        state_nxt = S_INIT2;
      end
      S_INIT2: begin
        wr_en = 1'b1; wr_off = 64'd8; wr_val = 64'(TAG_PROLOGUE);
        state_nxt = S_INIT3;
      end
      S_INIT3: begin
        wr_en = 1'b1; wr_off = 64'd12; wr_val = 64'(TAG_EPILOGUE);
        brk_nxt   = BW'(16);
        mode_nxt  = MD_INIT;
        state_nxt = S_G0;
      end
      S_IDLE: begin
        if (in_valid) begin
          st_nxt  = ST_OK;
          res_nxt = '0;
          if (in_op == OP_ALLOC) begin
            if (in_req_size == '0) begin
              st_nxt = ST_NOP; state_nxt = S_OUT;
            end else begin
              need_nxt  = (in_req_size <= 16'd8) ? 17'd16
                        : (({1'b0, in_req_size} + 17'd15) & ~17'd7);
              bp_nxt    = 64'd8;
              mode_nxt  = MD_ALLOC;
              state_nxt = S_FF0;
            end
          end else begin
            if (in_block_addr == '0) begin
              st_nxt = ST_NOP; state_nxt = S_OUT;
            end else begin
              bp_nxt    = {{(OFF_W-16){1'b0}}, in_block_addr};
              mode_nxt  = MD_FREE;
              state_nxt = S_F0;
            end
          end
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      // first-fit walk: one header per cycle
      S_FF0: begin
        rd_off = bp_r - 64'd4; state_nxt = S_FF1;
      end
      S_FF1: begin
        if (sz == '0) begin
          state_nxt = S_G0;
        end else if (!rv[0] && (need64 <= sz)) begin
          state_nxt = S_C0;
        end else begin
          bp_nxt = bp_r + sz;
          rd_off = bp_r + sz - 64'd4;
        end
      end
      S_G0: begin
        if ({{(OFF_W-BW){1'b0}}, brk_r} + grow_s > LIMIT) begin
          if (mode_r == MD_INIT) begin
            state_nxt = S_IDLE;
          end else begin
            st_nxt = ST_FULL; state_nxt = S_OUT;
          end
        end else begin
          bp_nxt  = {{(OFF_W-BW){1'b0}}, brk_r};
          brk_nxt = BW'({{(OFF_W-BW){1'b0}}, brk_r} + grow_s);
          s_nxt   = grow_s;
          wr_en = 1'b1; wr_off = {{(OFF_W-BW){1'b0}}, brk_r} - 64'd4; wr_val = grow_s;
          state_nxt = S_G1;
        end
      end
      S_G1: begin
        rd_off = bp_r - 64'd4; state_nxt = S_G2;
      end
      S_G2: begin
        wr_en = 1'b1; wr_off = bp_r + sz - 64'd8; wr_val = s_r;
        state_nxt = S_G3;
      end
      S_G3: begin
        rd_off = bp_r - 64'd4; state_nxt = S_G4;
      end
      S_G4: begin
        wr_en = 1'b1; wr_off = bp_r + sz - 64'd4; wr_val = 64'(TAG_EPILOGUE);
        state_nxt = S_M0;
      end
      // coalesce
      S_M0: begin
        rd_off = bp_r - 64'd8; state_nxt = S_M1;
      end
      S_M1: begin
        pv_nxt = bp_r - sz;
        rd_off = bp_r - sz - 64'd4;
        state_nxt = S_M2;
      end
      S_M2: begin
        psz_nxt = sz;
        rd_off  = pv_r + sz - 64'd8;
        state_nxt = S_M3;
      end
      S_M3: begin
        pu_nxt = rv[0];
        rd_off = bp_r - 64'd4;
        state_nxt = S_M4;
      end
      S_M4: begin
        s_nxt  = sz;
        a_nxt  = bp_r + sz;
        rd_off = bp_r + sz - 64'd4;
        state_nxt = S_M5;
      end
      S_M5: begin
        priority if (pu_r && rv[0]) begin
          state_nxt = merge_ret;
        end else if (pu_r) begin
          s_nxt = s_r + sz;
          wr_en = 1'b1; wr_off = bp_r - 64'd4; wr_val = s_r + sz;
          state_nxt = S_MP1;
        end else if (rv[0]) begin
          s_nxt = s_r + psz_r;
          wr_en = 1'b1; wr_off = bp_r + s_r - 64'd8; wr_val = s_r + psz_r;
          state_nxt = S_MN1;
        end else begin
          rd_off = a_r + sz - 64'd8;
          state_nxt = S_MB1;
        end
      end
      S_MP1: begin
        rd_off = bp_r - 64'd4; state_nxt = S_MP2;
      end
      S_MP2: begin
        wr_en = 1'b1; wr_off = bp_r + sz - 64'd8; wr_val = s_r;
        state_nxt = merge_ret;
      end
      S_MN1: begin
        rd_off = bp_r - 64'd8; state_nxt = S_MN2;
      end
      S_MN2: begin
        wr_en = 1'b1; wr_off = bp_r - sz - 64'd4; wr_val = s_r;
        state_nxt = S_MN3;
      end
      S_MN3: begin
        rd_off = bp_r - 64'd8; state_nxt = S_MN4;
      end
      S_MN4: begin
        bp_nxt = bp_r - sz; state_nxt = merge_ret;
      end
      S_MB1: begin
        s_nxt = s_r + psz_r + sz;
        wr_en = 1'b1; wr_off = pv_r - 64'd4; wr_val = s_r + psz_r + sz;
        state_nxt = S_MB2;
      end
      S_MB2: begin
        rd_off = bp_r - 64'd4; state_nxt = S_MB3;
      end
      S_MB3: begin
        a_nxt  = bp_r + sz;
        rd_off = bp_r + sz - 64'd4;
        state_nxt = S_MB4;
      end
      S_MB4: begin
        wr_en = 1'b1; wr_off = a_r + sz - 64'd8; wr_val = s_r;
        state_nxt = S_MB5;
      end
      S_MB5: begin
        rd_off = bp_r - 64'd8; state_nxt = S_MB6;
      end
      S_MB6: begin
        bp_nxt = bp_r - sz; state_nxt = merge_ret;
      end
      // place and split
      S_C0: begin
        rd_off = bp_r - 64'd4; state_nxt = S_C1;
      end
      S_C1: begin
        cs_nxt = sz[TAG_W-1:0];
        wr_en  = 1'b1;
        wr_off = bp_r - 64'd4;
        if (diff >= 64'd16) begin
          wr_val = need64 | 64'd1; state_nxt = S_CS1;
        end else begin
          wr_val = sz | 64'd1; state_nxt = S_CN1;
        end
      end
      S_CS1: begin
        rd_off = bp_r - 64'd4; state_nxt = S_CS2;
      end
      S_CS2: begin
        wr_en = 1'b1; wr_off = bp_r + sz - 64'd8; wr_val = need64 | 64'd1;
        a_nxt = bp_r + sz;
        state_nxt = S_CS3;
      end
      S_CS3: begin
        wr_en = 1'b1; wr_off = a_r - 64'd4;
        wr_val = 64'(cs_r - need64[TAG_W-1:0]);
        state_nxt = S_CS4;
      end
      S_CS4: begin
        rd_off = a_r - 64'd4; state_nxt = S_CS5;
      end
      S_CS5: begin
        wr_en = 1'b1; wr_off = a_r + sz - 64'd8;
        wr_val = 64'(cs_r - need64[TAG_W-1:0]);
        res_nxt = bp_r[15:0];
        state_nxt = S_OUT;
      end
      S_CN1: begin
        rd_off = bp_r - 64'd4; state_nxt = S_CN2;
      end
      S_CN2: begin
        wr_en = 1'b1; wr_off = bp_r + sz - 64'd8; wr_val = 64'(cs_r) | 64'd1;
        res_nxt = bp_r[15:0];
        state_nxt = S_OUT;
      end
      // free: clear the allocated bit in header and footer, then coalesce
      S_F0: begin
        rd_off = bp_r - 64'd4; state_nxt = S_F1;
      end
      S_F1: begin
        s_nxt = sz;
        wr_en = 1'b1; wr_off = bp_r - 64'd4; wr_val = sz;
        state_nxt = S_F2;
      end
      S_F2: begin
        rd_off = bp_r - 64'd4; state_nxt = S_F3;
      end
      S_F3: begin
        wr_en = 1'b1; wr_off = bp_r + sz - 64'd8; wr_val = s_r;
        state_nxt = S_M0;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      mode_r  <= MD_INIT;
      clr_r   <= '0;
      brk_r   <= '0;
      rd_in_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      clr_r   <= clr_nxt;
      brk_r   <= brk_nxt;
      rd_in_r <= (rd_off < LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    bp_r   <= bp_nxt;
    pv_r   <= pv_nxt;
    a_r    <= a_nxt;
    s_r    <= s_nxt;
    psz_r  <= psz_nxt;
    cs_r   <= cs_nxt;
    need_r <= need_nxt;
    pu_r   <= pu_nxt;
    res_r  <= res_nxt;
    st_r   <= st_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_result_addr = res_r;
  assign out_status      = st_r;

endmodule

### sv/ilha_tag_ram.sv
module ilha_tag_ram #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [ilha_pkg::TAG_W-1:0] wdata,
  input  logic [AW-1:0]          raddr,
  output logic [ilha_pkg::TAG_W-1:0] rdata
);
  import ilha_pkg::*;

  logic [TAG_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### sv/ilha_checker.sv
module ilha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_result_addr,
  input logic [1:0]  out_status
);
  import ilha_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_addr) && $stable(out_status))
    else $error("result beat changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("new request taken while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held after accept");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_result_addr == 16'd0)
    else $error("address given with non-ok status");

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK) || (out_status == ST_NOP) || (out_status == ST_FULL))
    else $error("undefined status code");

endmodule

bind implicit_list_heap_allocator ilha_checker u_ilha_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_result_addr (out_result_addr),
  .out_status      (out_status)
);

### test/implicit_list_heap_allocator_checker.sv
`timescale 1ns / 100ps

module implicit_list_heap_allocator_checker #(
  parameter int HEAP_WORDS  = 16384,
  parameter int CHUNK_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_op,
  input  logic [15:0] in_req_size,
  input  logic [15:0] in_block_addr,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_result_addr,
  input  logic [1:0]  out_status,
  output int          fail_count,
  output int          pending
);
  import ilha_pkg::*;

  typedef struct packed {
    logic [15:0] addr;
    logic [1:0]  status;
  } heap_reply_t;

  logic [31:0] heap_img [HEAP_WORDS];
  logic [63:0] heap_end;
  heap_reply_t replies_due [$];

  assign pending = replies_due.size();

  // out-of-store reads give 0, writes there are dropped
  function automatic logic [31:0] peek(logic [63:0] off);
    logic [63:0] w;
    w = off >> 2;
    if (w >= HEAP_WORDS) return 32'h0;
    return heap_img[w];
  endfunction

  function automatic void poke(logic [63:0] off, logic [63:0] v);
    logic [63:0] w;
    w = off >> 2;
    if (w < HEAP_WORDS) heap_img[w] = v[31:0];
  endfunction

  function automatic logic [63:0] hdr_size(logic [63:0] off);
    return {32'h0, peek(off) & ~32'h7};
  endfunction

  function automatic logic is_used(logic [63:0] off);
    logic [31:0] t;
    t = peek(off);
    return t[0];
  endfunction

  function automatic logic [63:0] foot_at(logic [63:0] bp);
    return bp + hdr_size(bp - 4) - 8;
  endfunction

  function automatic logic [63:0] next_bp(logic [63:0] bp);
    return bp + hdr_size(bp - 4);
  endfunction

  function automatic logic [63:0] prev_bp(logic [63:0] bp);
    return bp - hdr_size(bp - 8);
  endfunction

  function automatic logic [63:0] coalesce(logic [63:0] bp);
    logic pu, nu;
    logic [63:0] s;
    pu = is_used(foot_at(prev_bp(bp)));
    nu = is_used(next_bp(bp) - 4);
    s  = hdr_size(bp - 4);
    if (pu && nu) return bp;
    if (pu) begin
      s += hdr_size(next_bp(bp) - 4);
      poke(bp - 4, s);
      poke(foot_at(bp), s);
    end else if (nu) begin
      s += hdr_size(prev_bp(bp) - 4);
      poke(foot_at(bp), s);
      poke(prev_bp(bp) - 4, s);
      bp = prev_bp(bp);
    end else begin
      s += hdr_size(prev_bp(bp) - 4) + hdr_size(foot_at(next_bp(bp)));
      poke(prev_bp(bp) - 4, s);
      poke(foot_at(next_bp(bp)), s);
      bp = prev_bp(bp);
    end
    return bp;
  endfunction

  function automatic logic grow_heap(logic [63:0] bytes, output logic [63:0] bp);
    logic [63:0] w, s;
    w = bytes / 4;
    if (w[0]) w++;
    s = w * 4;
    bp = 0;
    if (heap_end + s > 64'(HEAP_WORDS) * 4) return 1'b0;
    bp = heap_end;
    heap_end = {32'h0, 32'(bp + s)};
    poke(bp - 4, s);
    poke(foot_at(bp), s);
    poke(next_bp(bp) - 4, 64'h1);
    bp = coalesce(bp);
    return 1'b1;
  endfunction

  function automatic logic scan_blocks(logic [63:0] need, output logic [63:0] bp);
    bp = 8;
    while (hdr_size(bp - 4) > 0) begin
      if (!is_used(bp - 4) && need <= hdr_size(bp - 4)) return 1'b1;
      bp = next_bp(bp);
    end
    return 1'b0;
  endfunction

  function automatic void place_block(logic [63:0] bp, logic [63:0] need);
    logic [63:0] cs, nb;
    cs = hdr_size(bp - 4);
    if (cs - need >= 16) begin
      poke(bp - 4, need | 1);
      poke(foot_at(bp), need | 1);
      nb = next_bp(bp);
      poke(nb - 4, cs - need);
      poke(foot_at(nb), cs - need);
    end else begin
      poke(bp - 4, cs | 1);
      poke(foot_at(bp), cs | 1);
    end
  endfunction

  function automatic void lay_out_heap();
    logic [63:0] bp;
    foreach (heap_img[i]) heap_img[i] = 32'h0;
    heap_img[1] = TAG_PROLOGUE;
    heap_img[2] = TAG_PROLOGUE;
    heap_img[3] = TAG_EPILOGUE;
    heap_end = 16;
    void'(grow_heap(64'(CHUNK_BYTES), bp));
  endfunction

  function automatic heap_reply_t serve_request(logic op, logic [15:0] rq, logic [15:0] ba);
    heap_reply_t r;
    logic [63:0] need, bp, ext, s, a;
    r.addr   = 16'h0;
    r.status = ST_OK;
    if (op == OP_ALLOC) begin
      if (rq == 0) begin
        r.status = ST_NOP;
      end else begin
        need = (rq <= 8) ? 64'd16 : 64'd8 * ((64'(rq) + 15) / 8);
        if (scan_blocks(need, bp)) begin
          place_block(bp, need);
          r.addr = bp[15:0];
        end else begin
          ext = (need > 64'(CHUNK_BYTES)) ? need : 64'(CHUNK_BYTES);
          if (grow_heap(ext, bp)) begin
            place_block(bp, need);
            r.addr = bp[15:0];
          end else begin
            r.status = ST_FULL;
          end
        end
      end
    end else if (ba == 0) begin
      r.status = ST_NOP;
    end else begin
      a = 64'(ba);
      s = hdr_size(a - 4);
      poke(a - 4, s);
      poke(foot_at(a), s);
      void'(coalesce(a));
    end
    return r;
  endfunction

  always @(posedge clk) begin
    heap_reply_t due;
    if (!rst_n) begin
      lay_out_heap();
      replies_due.delete();
      fail_count = 0;
    end else begin
      // compare before pushing so a beat can never match its own request
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $error("unexpected result beat: addr %0h status %0d", out_result_addr, out_status);
          fail_count++;
        end else begin
          due = replies_due.pop_front();
          if (out_result_addr !== due.addr) begin
            $error("result_addr mismatch: expected %0h, got %0h", due.addr, out_result_addr);
            fail_count++;
          end
          if (out_status !== due.status) begin
            $error("status mismatch: expected %0d, got %0d", due.status, out_status);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        replies_due.push_back(serve_request(in_op, in_req_size, in_block_addr));
    end
  end

endmodule

### test/implicit_list_heap_allocator_tb.sv
`timescale 1ns / 100ps

module implicit_list_heap_allocator_tb;
  import ilha_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_REQS = 950;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_op = OP_ALLOC;
  logic [15:0] in_req_size = 16'h0;
  logic [15:0] in_block_addr = 16'h0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_result_addr;
  logic [1:0]  out_status;
  int          fail_count;
  int          pending;

  int          tx_idle_pct = 20;
  int          rx_idle_pct = 78;
  int          cycles = 0;
  logic [15:0] live_blocks [$];
  logic [15:0] freed_blocks [$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  implicit_list_heap_allocator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_req_size(in_req_size), .in_block_addr(in_block_addr),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_addr(out_result_addr), .out_status(out_status)
  );

  implicit_list_heap_allocator_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_req_size(in_req_size), .in_block_addr(in_block_addr),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_addr(out_result_addr), .out_status(out_status),
    .fail_count(fail_count), .pending(pending)
  );

  always @(negedge clk) out_ready <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    // any nonzero address coming back is a fresh allocation
    if (out_valid && out_ready && out_result_addr != 0) live_blocks.push_back(out_result_addr);
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // hold the beat until the edge that takes it
  task automatic send_req(logic op, logic [15:0] rq, logic [15:0] ba);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_op         <= op;
    in_req_size   <= rq;
    in_block_addr <= ba;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic free_live(int idx, logic [1:0] skew);
    logic [15:0] a;
    a = live_blocks[idx];
    live_blocks.delete(idx);
    freed_blocks.push_back(a);
    if (freed_blocks.size() > 8) void'(freed_blocks.pop_front());
    send_req(OP_FREE, 16'($urandom), a | 16'(skew));
  endtask

  initial begin
    int pick;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: no-op requests, size rounding edges, growth and heap full
    send_req(OP_ALLOC, 16'h0, 16'($urandom));
    send_req(OP_FREE, 16'hFFFF, 16'h0);
    send_req(OP_ALLOC, 16'd1, 16'hFFFF);
    send_req(OP_ALLOC, 16'd8, 16'($urandom));
    send_req(OP_ALLOC, 16'd9, 16'($urandom));
    send_req(OP_ALLOC, 16'd16, 16'($urandom));
    send_req(OP_ALLOC, 16'hFFFF, 16'($urandom));
    send_req(OP_ALLOC, 16'd4000, 16'($urandom));
    send_req(OP_ALLOC, 16'd5000, 16'($urandom));
    send_req(OP_ALLOC, 16'd60000, 16'($urandom));
    drain();
    free_live(1, 2'd0);                  // neighbors allocated
    free_live(0, 2'd0);                  // merges with the freed block above
    free_live(live_blocks.size() - 1, 2'd3);  // unaligned offset
    send_req(OP_FREE, 16'($urandom), freed_blocks[0]);  // double free
    send_req(OP_FREE, 16'($urandom), 16'hFFFC);  // tags past the store
    send_req(OP_ALLOC, 16'd4088, 16'($urandom));
    send_req(OP_ALLOC, 16'd24, 16'($urandom));
    send_req(OP_ALLOC, 16'h8000, 16'($urandom));
    drain();

    for (int n = 0; n < RANDOM_REQS; n++) begin
      if (n == RANDOM_REQS / 3) begin
        tx_idle_pct = 78;
        rx_idle_pct = 20;
      end else if (n == 2 * RANDOM_REQS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 3) begin
        if (freed_blocks.size() != 0 && pick == 0)
          send_req(OP_FREE, 16'($urandom),
                   freed_blocks[$urandom_range(freed_blocks.size() - 1)]);
        else
          send_req(logic'(pick[0]), 16'h0, 16'h0);
      end else if (live_blocks.size() == 0 ||
                   (live_blocks.size() < 48 && pick < 55)) begin
        pick = $urandom_range(99);
        if (pick < 85)
          send_req(OP_ALLOC, 16'($urandom_range(256, 1)), 16'($urandom));
        else if (pick < 95)
          send_req(OP_ALLOC, 16'($urandom_range(4000, 257)), 16'($urandom));
        else
          send_req(OP_ALLOC, 16'($urandom), 16'($urandom));
      end else begin
        free_live($urandom_range(live_blocks.size() - 1),
                  ($urandom_range(3) == 0) ? 2'($urandom) : 2'd0);
      end
    end
    drain();
    repeat (64) @(posedge clk);

    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
